// ===== src/oaht_pkg.sv =====
// Package for the open-address hash table: request, status and state codes.
// No dependencies.
`timescale 1ns / 1ps
package oaht_pkg;
    localparam int TABLE_DEPTH_DEF = 256;
    localparam int KEY_DIGITS_DEF  = 16;
    localparam int CHUNK_DIGITS    = 7;
    localparam int CHUNK_BITS      = 4 * CHUNK_DIGITS;

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_FIND   = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [1:0] CFG_SIZE  = 2'd0;
    localparam logic [1:0] CFG_HASH  = 2'd1;
    localparam logic [1:0] CFG_PROBE = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_SETUP = 3'd1;
    localparam logic [2:0] ST_EMPTY_KEY = 3'd2;
    localparam logic [2:0] ST_EMPTY_VAL = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_NO_INSERT = 3'd5;
    localparam logic [2:0] ST_DUPLICATE = 3'd6;
    localparam logic [2:0] ST_NOT_FOUND = 3'd7;

    typedef enum logic [3:0] {
        S_IDLE, S_HASH, S_MOD, S_CLEAR, S_READ, S_CHECK, S_STEP, S_DONE
    } t_state;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_mod_ctl;
endpackage

// ===== src/open_address_hash_table.sv =====
// Open-address hash table, top level: control sequencer, hash, probe walk.
// Sequence: add/find go through a check state, a modulo pass (two with double hashing),
// read, check and step states per probe and a done state; rejected items go to done.
// Clear sweeps the occupied memory, then a done state.
// Throughput: one item at a time; busy is high until the result strobe; no stalls.
// Reset: synchronous active low; a clearing pass over the occupied memory runs with busy high.
`timescale 1ns / 1ps
module open_address_hash_table #(
    parameter int TABLE_DEPTH = oaht_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_DIGITS  = oaht_pkg::KEY_DIGITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data,
    input  logic [1:0]  i_req_type,
    input  logic [63:0] i_key_value,
    input  logic [4:0]  i_key_digits,
    input  logic [63:0] i_value_word,
    input  logic        i_value_present,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [63:0] o_found_value,
    output logic [8:0]  o_probe_count
);
    import oaht_pkg::*;
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SW = $clog2(TABLE_DEPTH + 1);
    localparam int MODB = (SW > 9) ? SW : 9;

    t_state r_state, n_state;
    logic [8:0]  r_size_cfg;
    logic        r_hsel, r_pmode;
    logic [SW-1:0] r_count, r_size, r_p;
    logic [1:0]  r_req;
    logic [63:0] r_key, r_val;
    logic [4:0]  r_nd;
    logic        r_vp;
    logic [CHUNK_BITS-1:0] r_h2;
    logic [AW-1:0] r_idx, r_step, r_clr;
    logic        r_second;
    logic [2:0]  r_status;
    logic [63:0] r_fval;
    logic [8:0]  r_probes;
    logic        r_clr_last;
    logic        r_init;

    // key normalization
    logic [4:0]  nd_c;
    logic [63:0] key_c;
    always_comb begin
        nd_c = (i_key_digits > 5'(KEY_DIGITS)) ? 5'(KEY_DIGITS) : i_key_digits;
        key_c = (nd_c >= 5'd16) ? i_key_value
              : (i_key_value & ((64'd1 << {nd_c, 2'b00}) - 64'd1));
    end

    // hashes, from registered key
    logic [CHUNK_BITS-1:0] last7, hxor;
    logic [63:0] sh;
    logic [4:0]  rem, len;
    always_comb begin
        last7 = (r_nd >= 5'd7) ? r_key[CHUNK_BITS-1:0]
              : r_key[CHUNK_BITS-1:0] & ((28'd1 << {r_nd, 2'b00}) - 28'd1);
        hxor = '0;
        rem  = r_nd;
        for (int s = 0; s < 3; s++) begin
            len = (rem < 5'd7) ? rem : 5'd7;
            sh  = r_key >> {rem - len, 2'b00};
            if (rem != 5'd0)
                hxor = hxor ^ (sh[CHUNK_BITS-1:0]
                       & ((28'd1 << {len, 2'b00}) - 28'd1));
            rem = rem - len;
        end
    end

    // request checks
    logic [2:0] chk_status;
    logic       chk_err;
    always_comb begin
        chk_err = 1'b1;
        if (r_size == '0) chk_status = ST_NOT_SETUP;
        else if (r_nd == 5'd0) chk_status = ST_EMPTY_KEY;
        else if (r_req == REQ_ADD && !r_vp) chk_status = ST_EMPTY_VAL;
        else if (r_req == REQ_ADD && r_count >= r_size) chk_status = ST_FULL;
        else begin
            chk_err    = 1'b0;
            chk_status = (r_req == REQ_ADD) ? ST_NO_INSERT : ST_NOT_FOUND;
        end
    end

    // modulo unit: home slot from the live primary hash, then the step
    logic mod_start, mod_done;
    logic [MODB-1:0] mod_rem;
    logic [CHUNK_BITS-1:0] mod_a;
    assign mod_a = (r_state == S_HASH) ? (r_hsel ? last7 : hxor) : r_h2;
    oaht_mod #(.AW(CHUNK_BITS), .BW(MODB)) u_mod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mod_start),
        .i_a(mod_a), .i_b(MODB'(r_size)),
        .o_done(mod_done), .o_rem(mod_rem)
    );

    // memory
    logic [AW-1:0] m_addr;
    logic m_we, m_occ_we, m_occ;
    logic [63:0] rd_key, rd_val;
    logic [4:0]  rd_len;
    logic rd_occ;
    oaht_store #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_store (
        .i_clk(i_clk), .i_addr(m_addr), .i_we(m_we), .i_key(r_key),
        .i_len(r_nd), .i_val(r_val), .i_occ_we(m_occ_we), .i_occ(m_occ),
        .o_key(rd_key), .o_len(rd_len), .o_val(rd_val), .o_occ(rd_occ)
    );

    logic hit, last_probe;
    logic [SW:0] nidx;
    assign hit = (rd_len == r_nd) && (rd_key == r_key);
    assign last_probe = (r_p + 1'b1 >= r_size);
    assign nidx = (SW+1)'(r_idx) + (SW+1)'(r_step);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (start) n_state = (i_req_type == REQ_CLEAR) ? S_CLEAR :
                         (i_req_type == REQ_ADD || i_req_type == REQ_FIND) ? S_HASH
                         : S_DONE;
            S_HASH:  n_state = chk_err ? S_DONE : S_MOD;
            S_MOD:   if (mod_done && (r_second || !r_pmode)) n_state = S_READ;
            S_CLEAR: if (r_clr_last) n_state = r_init ? S_IDLE : S_DONE;
            S_READ:  n_state = S_CHECK;
            S_CHECK: n_state = (!rd_occ || hit || last_probe) ? S_DONE : S_STEP;
            S_STEP:  n_state = S_READ;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        busy      = (r_state != S_IDLE);
        mod_start = 1'b0;
        m_addr    = r_idx;
        m_we      = 1'b0;
        m_occ_we  = 1'b0;
        m_occ     = 1'b0;
        case (r_state)
            S_HASH:  mod_start = !chk_err;
            S_MOD:   mod_start = mod_done && !r_second && r_pmode;
            S_CLEAR: begin
                m_addr   = r_clr;
                m_occ_we = 1'b1;
            end
            S_CHECK: begin
                m_we     = !rd_occ && (r_req == REQ_ADD);
                m_occ_we = m_we;
                m_occ    = 1'b1;
            end
            default: ;
        endcase
    end

    assign o_done        = (r_state == S_DONE);
    assign o_status      = r_status;
    assign o_found_value = r_fval;
    assign o_probe_count = r_probes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_req      <= REQ_CLEAR;
            r_size_cfg <= '0;
            r_hsel     <= 1'b0;
            r_pmode    <= 1'b0;
            r_count    <= '0;
            r_clr      <= '0;
            r_clr_last <= (TABLE_DEPTH == 1);
            r_init     <= 1'b1;
            r_status   <= ST_OK;
            r_fval     <= '0;
            r_probes   <= '0;
            r_second   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SIZE:  r_size_cfg <= i_cfg_data;
                    CFG_HASH:  r_hsel     <= i_cfg_data[0];
                    CFG_PROBE: r_pmode    <= i_cfg_data[0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: if (start) begin
                    r_req    <= i_req_type;
                    r_key    <= key_c;
                    r_nd     <= nd_c;
                    r_val    <= i_value_word;
                    r_vp     <= i_value_present;
                    r_size   <= ({23'd0, r_size_cfg} > 32'(TABLE_DEPTH)) ?
                                SW'(TABLE_DEPTH) : SW'(r_size_cfg);
                    r_fval   <= '0;
                    r_probes <= '0;
                    r_p      <= '0;
                    r_second <= 1'b0;
                    r_clr    <= '0;
                    r_clr_last <= (TABLE_DEPTH == 1);
                    r_status <= ST_OK;
                end
                S_HASH: begin
                    r_h2     <= r_hsel ? hxor : last7;
                    r_status <= chk_status;
                end
                S_MOD: if (mod_done) begin
                    if (!r_second) begin
                        r_idx    <= AW'(mod_rem);
                        r_step   <= AW'(1);
                        r_second <= 1'b1;
                    end else if (mod_rem != '0) begin
                        r_step <= AW'(mod_rem);
                    end
                end
                S_CLEAR: begin
                    r_clr      <= r_clr + 1'b1;
                    r_clr_last <= (32'(r_clr) + 32'd2 >= 32'(TABLE_DEPTH));
                    r_count    <= '0;
                    if (r_clr_last) r_init <= 1'b0;
                end
                S_CHECK: begin
                    if (!rd_occ) begin
                        if (r_req == REQ_ADD) begin
                            r_status <= ST_OK;
                            r_count  <= r_count + 1'b1;
                        end
                    end else if (hit) begin
                        if (r_req == REQ_ADD) r_status <= ST_DUPLICATE;
                        else begin
                            r_status <= ST_OK;
                            r_fval   <= rd_val;
                            r_probes <= 9'(r_p);
                        end
                    end
                end
                S_STEP: begin
                    r_p   <= r_p + 1'b1;
                    r_idx <= (nidx >= (SW+1)'(r_size)) ?
                             AW'(nidx - (SW+1)'(r_size)) : AW'(nidx);
                end
                default: ;
            endcase
        end
    end
endmodule

// ===== src/oaht_mod.sv =====
// Restoring remainder unit: a % b, one quotient bit per cycle.
// Depends on oaht_pkg.
`timescale 1ns / 1ps
module oaht_mod #(
    parameter int AW = 28,
    parameter int BW = 17
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [AW-1:0]   i_a,
    input  logic [BW-1:0]   i_b,
    output logic            o_done,
    output logic [BW-1:0]   o_rem
);
    import oaht_pkg::*;
    localparam int CW = $clog2(AW + 1);

    logic [AW-1:0] r_a;
    logic [BW-1:0] r_b;
    logic [BW:0]   r_rem;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [BW:0]   n_shift;

    assign n_shift = {r_rem[BW-1:0], r_a[AW-1]};
    assign o_done  = r_done;
    assign o_rem   = r_rem[BW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_rem  <= '0;
                r_cnt  <= CW'(AW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_a <= {r_a[AW-2:0], 1'b0};
                if (n_shift >= {1'b0, r_b}) r_rem <= n_shift - {1'b0, r_b};
                else r_rem <= n_shift;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

// ===== src/oaht_store.sv =====
// Slot memory: key, length, value in one RAM; occupied bits in a second RAM.
// Depends on oaht_pkg.
`timescale 1ns / 1ps
module oaht_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic [AW-1:0] i_addr,
    input  logic          i_we,
    input  logic [63:0]   i_key,
    input  logic [4:0]    i_len,
    input  logic [63:0]   i_val,
    input  logic          i_occ_we,
    input  logic          i_occ,
    output logic [63:0]   o_key,
    output logic [4:0]    o_len,
    output logic [63:0]   o_val,
    output logic          o_occ
);
    import oaht_pkg::*;
    logic [132:0] r_mem [DEPTH];
    logic         r_occ_mem [DEPTH];
    logic [132:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= {i_key, i_len, i_val};
        r_rd <= r_mem[i_addr];
    end
    always_ff @(posedge i_clk) begin
        if (i_occ_we) r_occ_mem[i_addr] <= i_occ;
        o_occ <= r_occ_mem[i_addr];
    end
    assign o_key = r_rd[132:69];
    assign o_len = r_rd[68:64];
    assign o_val = r_rd[63:0];
endmodule

// ===== tb/sv/open_address_hash_table_tb.sv =====
// Testbench for open_address_hash_table: directed and random add/find/clear items,
// checked against a behavioral hash table kept in the bench. Depends on oaht_pkg.
`timescale 1ns / 1ps
module open_address_hash_table_tb;
    import oaht_pkg::*;

    localparam int DEPTH = 256;
    localparam int WDOG_LIMIT = 400000;

    typedef struct {
        logic [1:0]  req;
        logic [63:0] key;
        logic [4:0]  digits;
        logic [63:0] value;
        logic        vpres;
    } t_item;

    typedef struct {
        logic [2:0]  status;
        logic [63:0] fval;
        logic [8:0]  probes;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [8:0]  i_cfg_data = '0;
    logic [1:0]  i_req_type = '0;
    logic [63:0] i_key_value = '0;
    logic [4:0]  i_key_digits = '0;
    logic [63:0] i_value_word = '0;
    logic        i_value_present = 1'b0;
    logic        o_done;
    logic [2:0]  o_status;
    logic [63:0] o_found_value;
    logic [8:0]  o_probe_count;

    open_address_hash_table DUT (.*);

    always #5 i_clk = ~i_clk;

    // bench copy of the table
    logic [63:0] tbl_key [DEPTH];
    logic [4:0]  tbl_len [DEPTH];
    logic [63:0] tbl_val [DEPTH];
    bit          tbl_used [DEPTH];
    int unsigned tbl_count;
    int unsigned cfg_size;
    bit          cfg_hash;
    bit          cfg_probe;

    t_item   pending_items[$];
    t_result expected_results[$];
    int      send_idle_pct = 0;
    bit      send_hold = 1'b0;
    int      errors = 0;
    int      wdog = 0;
    t_item   keys_added[$];

    function automatic logic [63:0] digit_mask(int n);
        if (n >= 16) return '1;
        return (64'd1 << (4 * n)) - 64'd1;
    endfunction

    function automatic logic [63:0] last_seven(logic [63:0] k, int n);
        return k & digit_mask(n < CHUNK_DIGITS ? n : CHUNK_DIGITS);
    endfunction

    function automatic logic [63:0] chunk_xor(logic [63:0] k, int n);
        logic [63:0] acc;
        int len;
        acc = '0;
        for (int s = 0; s < n; s += CHUNK_DIGITS) begin
            len = (n - s < CHUNK_DIGITS) ? n - s : CHUNK_DIGITS;
            acc ^= (k >> (4 * (n - s - len))) & digit_mask(len);
        end
        return acc;
    endfunction

    function automatic t_result table_lookup(t_item it);
        t_result r;
        int nd;
        int unsigned sz, idx, stp;
        logic [63:0] k, h1, h2;
        r = '{ST_OK, 64'd0, 9'd0};
        nd = (it.digits > 16) ? 16 : it.digits;
        k = it.key & digit_mask(nd);
        sz = (cfg_size > DEPTH) ? DEPTH : cfg_size;
        if (it.req == REQ_CLEAR) begin
            foreach (tbl_used[i]) tbl_used[i] = 1'b0;
            tbl_count = 0;
        end else if (it.req == REQ_ADD || it.req == REQ_FIND) begin
            if (sz == 0) r.status = ST_NOT_SETUP;
            else if (nd == 0) r.status = ST_EMPTY_KEY;
            else if (it.req == REQ_ADD && !it.vpres) r.status = ST_EMPTY_VAL;
            else if (it.req == REQ_ADD && tbl_count >= sz) r.status = ST_FULL;
            else begin
                h1 = cfg_hash ? last_seven(k, nd) : chunk_xor(k, nd);
                h2 = cfg_hash ? chunk_xor(k, nd) : last_seven(k, nd);
                idx = 32'(h1 % sz);
                stp = cfg_probe ? 32'(h2 % sz) : 1;
                if (stp == 0) stp = 1;
                r.status = (it.req == REQ_ADD) ? ST_NO_INSERT : ST_NOT_FOUND;
                for (int p = 0; p < sz; p++) begin
                    if (!tbl_used[idx]) begin
                        if (it.req == REQ_ADD) begin
                            tbl_used[idx] = 1'b1;
                            tbl_key[idx] = k;
                            tbl_len[idx] = 5'(nd);
                            tbl_val[idx] = it.value;
                            tbl_count++;
                            r.status = ST_OK;
                        end
                        break;
                    end
                    if (tbl_len[idx] == nd && tbl_key[idx] == k) begin
                        if (it.req == REQ_ADD) r.status = ST_DUPLICATE;
                        else begin
                            r.status = ST_OK;
                            r.fval = tbl_val[idx];
                            r.probes = 9'(p);
                        end
                        break;
                    end
                    idx = (idx + stp) % sz;
                end
            end
        end
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            expected_results.push_back(table_lookup(pending_items.pop_front()));
        end
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !busy) begin
            if (pending_items.size() > 0 && !send_hold
                    && $urandom_range(99) >= send_idle_pct) begin
                i_req_type      <= pending_items[0].req;
                i_key_value     <= pending_items[0].key;
                i_key_digits    <= pending_items[0].digits;
                i_value_word    <= pending_items[0].value;
                i_value_present <= pending_items[0].vpres;
            end else begin
                start <= 1'b0;
            end
        end else if (!start && pending_items.size() > 0 && !send_hold
                && $urandom_range(99) >= send_idle_pct) begin
            start           <= 1'b1;
            i_req_type      <= pending_items[0].req;
            i_key_value     <= pending_items[0].key;
            i_key_digits    <= pending_items[0].digits;
            i_value_word    <= pending_items[0].value;
            i_value_present <= pending_items[0].vpres;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                $error("result with nothing expected: status %0d", o_status);
                errors++;
            end else begin
                exp_r = expected_results.pop_front();
                if (o_status !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, o_status);
                    errors++;
                end
                if (o_found_value !== exp_r.fval) begin
                    $error("found_value: expected %h, got %h", exp_r.fval, o_found_value);
                    errors++;
                end
                if (o_probe_count !== exp_r.probes) begin
                    $error("probe_count: expected %0d, got %0d",
                           exp_r.probes, o_probe_count);
                    errors++;
                end
            end
        end
        if (o_done || (start && !busy) || !i_rst_n) wdog = 0;
        else wdog++;
        if (wdog >= WDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, int unsigned data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= 9'(data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_SIZE: cfg_size  = data & 9'h1FF;
            CFG_HASH: cfg_hash  = data[0];
            default:  cfg_probe = data[0];
        endcase
    endtask

    task automatic drain_results();
        while (pending_items.size() > 0 || expected_results.size() > 0 || start)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic queue_item(logic [1:0] req, logic [63:0] key, logic [4:0] nd,
                              logic [63:0] val, logic vp);
        t_item it;
        it = '{req, key, nd, val, vp};
        pending_items.push_back(it);
        if (req == REQ_ADD && vp && nd != 0) keys_added.push_back(it);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic random_phase(int count, int idle);
        t_item prev;
        int sel, nd;
        send_idle_pct = idle;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            nd = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(1, 16);
            if (sel < 45) begin
                queue_item(REQ_ADD, rand64(), 5'(nd), rand64(), $urandom_range(19) != 0);
            end else if (sel < 80 && keys_added.size() > 0) begin
                prev = keys_added[$urandom_range(keys_added.size() - 1)];
                queue_item(($urandom_range(3) == 0) ? REQ_ADD : REQ_FIND,
                           prev.key, prev.digits, rand64(), 1'b1);
            end else if (sel < 92) begin
                queue_item(REQ_FIND, rand64(), 5'(nd), rand64(), 1'($urandom_range(1)));
            end else if (sel < 95) begin
                queue_item(REQ_ADD, rand64(), 5'd0, rand64(), 1'b1);
            end else if (sel < 98) begin
                queue_item(REQ_CLEAR, rand64(), 5'(nd), rand64(), 1'($urandom_range(1)));
                keys_added.delete();
            end else begin
                queue_item(REQ_UNUSED, rand64(), 5'(nd), rand64(), 1'($urandom_range(1)));
            end
        end
        drain_results();
    endtask

    initial begin
        tbl_count = 0;
        cfg_size = 0;
        cfg_hash = 1'b0;
        cfg_probe = 1'b0;
        foreach (tbl_used[i]) tbl_used[i] = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // not set up, then a tiny table to hit the empty key, empty value and full checks
        queue_item(REQ_ADD, 64'h1, 5'd1, 64'h5, 1'b1);
        queue_item(REQ_FIND, 64'h1, 5'd1, 64'h0, 1'b0);
        drain_results();
        write_reg(CFG_SIZE, 2);
        queue_item(REQ_ADD, 64'h0, 5'd0, 64'h1, 1'b1);
        queue_item(REQ_ADD, 64'hA, 5'd1, 64'h1, 1'b0);
        queue_item(REQ_ADD, 64'hA, 5'd1, '1, 1'b1);
        queue_item(REQ_ADD, 64'hA, 5'd2, 64'h2, 1'b1);
        queue_item(REQ_ADD, 64'hA, 5'd1, 64'h3, 1'b1);
        queue_item(REQ_FIND, 64'hA, 5'd2, 64'h0, 1'b0);
        queue_item(REQ_FIND, 64'hA, 5'd1, 64'h0, 1'b0);
        queue_item(REQ_FIND, 64'hB, 5'd1, 64'h0, 1'b0);
        queue_item(REQ_ADD, 64'hC, 5'd1, 64'h4, 1'b1);
        queue_item(REQ_UNUSED, '1, 5'd16, '1, 1'b1);
        queue_item(REQ_CLEAR, 64'h0, 5'd0, 64'h0, 1'b0);
        queue_item(REQ_ADD, '1, 5'd31, '1, 1'b1);
        queue_item(REQ_FIND, '1, 5'd16, 64'h0, 1'b0);
        queue_item(REQ_FIND, 64'h0123456789ABCDEF, 5'd17, 64'h0, 1'b0);
        drain_results();
        // cannot insert: double hashing step divides size
        write_reg(CFG_SIZE, 4);
        write_reg(CFG_PROBE, 1);
        queue_item(REQ_CLEAR, 64'h0, 5'd0, 64'h0, 1'b0);
        queue_item(REQ_ADD, 64'h02, 5'd2, 64'h1, 1'b1);
        queue_item(REQ_ADD, 64'h12, 5'd2, 64'h2, 1'b1);
        queue_item(REQ_ADD, 64'h22, 5'd2, 64'h3, 1'b1);
        queue_item(REQ_FIND, 64'h12, 5'd2, 64'h0, 1'b0);
        drain_results();

        write_reg(CFG_SIZE, 256);
        write_reg(CFG_HASH, 1);
        write_reg(CFG_PROBE, 0);
        random_phase(250, 0);
        send_hold = 1'b1;
        drain_results();
        send_hold = 1'b0;
        write_reg(CFG_SIZE, 511);
        write_reg(CFG_HASH, 0);
        write_reg(CFG_PROBE, 1);
        random_phase(250, 67);
        write_reg(CFG_SIZE, 1);
        write_reg(CFG_PROBE, 0);
        random_phase(150, 0);
        write_reg(CFG_SIZE, 37);
        write_reg(CFG_HASH, 1);
        write_reg(CFG_PROBE, 1);
        random_phase(250, 36);
        write_reg(CFG_SIZE, 13);
        write_reg(CFG_HASH, 0);
        write_reg(CFG_PROBE, 0);
        random_phase(300, 67);

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// ===== files.f =====
src/oaht_pkg.sv
src/oaht_mod.sv
src/oaht_store.sv
src/open_address_hash_table.sv
tb/sv/open_address_hash_table_tb.sv
